// ===== src/dmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmsc_pkg
// Shared types and constants for the direct-mapped search cache: command and
// response words, slot layout, operation and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dmsc_pkg;

    // Default geometry
    localparam int INDEX_BITS_DEF   = 16;
    localparam int SAMPLE_COUNT_DEF = 1000;

    // Operation codes
    localparam logic [1:0] FUNC_PROBE = 2'd0;
    localparam logic [1:0] FUNC_STORE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_FILL  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_AGE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATE_THRESHOLD = 2'd1;
    localparam int CFG_DATA_W = 15;

    // Register reset values
    localparam logic [7:0]  AGE_RST            = 8'd0;
    localparam logic [14:0] MATE_THRESHOLD_RST = 15'd31000;

    // Fill count saturates here
    localparam logic [9:0] FILL_MAX = 10'd1023;

    // Input word
    typedef struct packed {
        logic [1:0]         func;
        logic [63:0]        lookup_key;
        logic [7:0]         search_depth;
        logic signed [15:0] result_score;
        logic signed [15:0] static_eval;
        logic [1:0]         bound_kind;
        logic [15:0]        best_move;
        logic [7:0]         ply_from_root;
    } t_cmd;

    // Result word
    typedef struct packed {
        logic               hit;
        logic signed [15:0] entry_score;
        logic signed [15:0] adjusted_score;
        logic signed [15:0] entry_eval;
        logic [15:0]        entry_move;
        logic [7:0]         entry_depth;
        logic [1:0]         entry_flag;
        logic [7:0]         entry_age;
        logic [9:0]         fill_count;
    } t_rsp;

    // One cache slot
    typedef struct packed {
        logic [63:0]        key;
        logic signed [15:0] score;
        logic signed [15:0] eval;
        logic [15:0]        move;
        logic [7:0]         depth;
        logic [1:0]         flag;
        logic [7:0]         age;
    } t_slot;

endpackage

`default_nettype wire

// ===== src/direct_mapped_search_cache.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_search_cache
// Direct-mapped cache of search results with probe, store, clear and fill
// count, built around one slot memory and a small sequencer.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake               | word
//  ----------+-----------+-------------------------+---------------
//  command   | in        | start & !busy           | i_cmd (t_cmd)
//  response  | out       | o_done, one cycle       | o_rsp (t_rsp)
//  config    | in        | i_cfg_valid&o_cfg_ready | index + data
//
//  Probe and store do one memory read, then the compare, the
//  shared mate-adjust adder and the write-back.
//  Clear writes all 2^INDEX_BITS slots, one slot written per cycle.
//  Fill count reads min(SAMPLE_COUNT, 2^INDEX_BITS) slots, one slot read
//  per cycle through the single read port.
//  After reset a clearing pass over all 2^INDEX_BITS slots runs with busy high;
//  config writes are taken at any time. The response cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_search_cache
    import dmsc_pkg::*;
#(
    parameter int INDEX_BITS   = INDEX_BITS_DEF,
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire t_cmd                  i_cmd,
    output      logic                  o_done,
    output      t_rsp                  o_rsp,
    input  wire logic                  i_cfg_valid,
    output      logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOTS     = 1 << INDEX_BITS;
    localparam int SAMPLES   = (SAMPLE_COUNT > SLOTS) ? SLOTS : SAMPLE_COUNT;
    localparam logic [INDEX_BITS-1:0] LAST_SAMPLE = INDEX_BITS'(SAMPLES - 1);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_CLEAR = 6'b001000,
        S_COUNT = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_req;
    logic [INDEX_BITS-1:0] r_idx, n_idx;
    logic [9:0]            r_fill, n_fill;
    logic                  r_rd_vld;
    logic [7:0]            r_age;
    logic [14:0]           r_thr;
    logic                  r_done, n_done;
    t_rsp                  r_rsp, n_rsp;

    t_slot                 r_mem [SLOTS];
    t_slot                 r_rd;
    logic [INDEX_BITS-1:0] w_rd_addr;
    logic [INDEX_BITS-1:0] w_wr_addr;
    logic                  w_we;
    t_slot                 w_wr_data;

    logic                  w_accept;
    logic                  w_probe;
    logic                  w_same;
    logic                  w_replace;
    logic signed [15:0]    w_src;
    logic signed [16:0]    w_src_x;
    logic signed [16:0]    w_thr_x;
    logic                  w_pos;
    logic                  w_neg;
    logic                  w_sub;
    logic [15:0]           w_delta;
    logic signed [15:0]    w_adj;
    logic                  w_cnt_hit;

    assign w_accept    = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // Select the read address: lookup slot on accept, sweep index otherwise
    always_comb begin
        if (r_state == S_IDLE) begin
            w_rd_addr = i_cmd.lookup_key[INDEX_BITS-1:0];
        end else begin
            w_rd_addr = r_idx;
        end
    end

    // Shared mate-adjust adder, fed by the stored score on probe
    assign w_probe = (r_req.func == FUNC_PROBE);
    assign w_src   = w_probe ? r_rd.score : r_req.result_score;
    assign w_src_x = {w_src[15], w_src};
    assign w_thr_x = {2'b00, r_thr};
    assign w_pos   = (w_src_x >= w_thr_x);
    assign w_neg   = !w_pos && (w_src_x <= -w_thr_x);
    assign w_sub   = w_pos ? w_probe : !w_probe;
    assign w_delta = (w_pos || w_neg) ? {8'd0, r_req.ply_from_root} : 16'd0;
    assign w_adj   = w_sub ? (w_src - $signed(w_delta)) : (w_src + $signed(w_delta));

    // Tag compare and replacement rule
    assign w_same    = (r_rd.key == r_req.lookup_key);
    assign w_replace = !w_same || (r_req.search_depth >= r_rd.depth) || (r_rd.age != r_age);

    // Slot counted by fill count
    assign w_cnt_hit = r_rd_vld && (r_rd.flag != 2'd0) && (r_rd.age == r_age);

    // Sequencer, write port and response
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_done    = 1'b0;
        n_rsp     = '0;
        w_we      = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = '0;

        if (w_cnt_hit && (r_fill != FILL_MAX)) begin
            n_fill = r_fill + 10'd1;
        end

        case (r_state)
            S_INIT, S_CLEAR: begin
                w_we  = 1'b1;
                n_idx = r_idx + 1'b1;
                if (&r_idx) begin
                    n_state = S_IDLE;
                    n_done  = (r_state == S_CLEAR);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_idx  = '0;
                    n_fill = '0;
                    case (i_cmd.func)
                        FUNC_CLEAR: n_state = S_CLEAR;
                        FUNC_FILL:  n_state = S_COUNT;
                        default:    n_state = S_EXEC;
                    endcase
                end
            end
            S_EXEC: begin
                n_state   = S_IDLE;
                n_done    = 1'b1;
                w_wr_addr = r_req.lookup_key[INDEX_BITS-1:0];
                if (w_probe) begin
                    if (w_same && (r_rd.flag != 2'd0)) begin
                        n_rsp.hit            = 1'b1;
                        n_rsp.entry_score    = r_rd.score;
                        n_rsp.adjusted_score = w_adj;
                        n_rsp.entry_eval     = r_rd.eval;
                        n_rsp.entry_move     = r_rd.move;
                        n_rsp.entry_depth    = r_rd.depth;
                        n_rsp.entry_flag     = r_rd.flag;
                        n_rsp.entry_age      = r_rd.age;
                    end
                end else begin
                    w_we            = w_replace;
                    w_wr_data.key   = r_req.lookup_key;
                    w_wr_data.score = w_adj;
                    w_wr_data.eval  = r_req.static_eval;
                    w_wr_data.move  = ((r_req.best_move == 16'd0) && w_same) ?
                                      r_rd.move : r_req.best_move;
                    w_wr_data.depth = r_req.search_depth;
                    w_wr_data.flag  = r_req.bound_kind;
                    w_wr_data.age   = r_age;
                end
            end
            S_COUNT: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_SAMPLE) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state          = S_IDLE;
                n_done           = 1'b1;
                n_rsp.fill_count = n_fill;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_idx    <= '0;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
            r_age    <= AGE_RST;
            r_thr    <= MATE_THRESHOLD_RST;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_fill   <= n_fill;
            r_rd_vld <= (r_state == S_COUNT);
            r_done   <= n_done;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CURRENT_AGE:    r_age <= i_cfg_data[7:0];
                    CFG_MATE_THRESHOLD: r_thr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers: hold the accepted word and the response
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_cmd;
        end
        r_rsp <= n_rsp;
    end

endmodule

`default_nettype wire

// ===== src/dmsc_checker.sv =====
// ----------------------------------------------------------------------------
// dmsc_checker
// Port-level checks on the search cache: handshake timing and the shape of
// response words.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsc_checker
    import dmsc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire t_rsp o_rsp
);

    // Reset starts the clearing pass
    a_init_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // An accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // A response follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("response without work in progress");

    // A hit always carries a non-empty flag
    a_hit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.hit) |-> (o_rsp.entry_flag != 2'd0))
        else $error("hit reported on an empty entry");

    // A miss returns zero entry score, flag and move
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.hit) |-> (o_rsp.entry_score == 16'sd0 &&
            o_rsp.entry_flag == 2'd0 && o_rsp.entry_move == 16'd0))
        else $error("miss with nonzero entry fields");

endmodule

bind direct_mapped_search_cache dmsc_checker u_dmsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the direct-mapped search cache. Probe, store,
// clear and fill count words are driven in bursts. A scoreboard keeps its
// own copy of the slot table and both registers. Every response word is
// checked field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import dmsc_pkg::*;

    localparam int SLOT_COUNT  = 1 << INDEX_BITS_DEF;
    localparam int FILL_WINDOW = (SAMPLE_COUNT_DEF < SLOT_COUNT) ? SAMPLE_COUNT_DEF
                                                                : SLOT_COUNT;
    localparam int PHASE_ITEMS = 345;
    localparam int CYCLE_LIMIT = 4_000_000;

    // Mirror of the slot table plus the queue of predicted response words
    class search_cache_scoreboard;
        t_slot       slots [0:SLOT_COUNT-1];
        t_rsp        predicted_rsp [$];
        logic [7:0]  cur_age;
        logic [14:0] mate_limit;
        int          mismatches;
        int          probes, hits, stores, clears, fills;

        function new();
            wipe_slots();
            cur_age    = AGE_RST;
            mate_limit = MATE_THRESHOLD_RST;
        endfunction

        function void wipe_slots();
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_CURRENT_AGE)
                cur_age = data[7:0];
            else if (idx == CFG_MATE_THRESHOLD)
                mate_limit = data;
        endfunction

        // Move a mate score between root and node distance, wrapping to 16 bits
        function logic [15:0] mate_shift(logic signed [15:0] s, logic [7:0] ply, bit storing);
            int lim, v, p, r;
            lim = mate_limit;
            v   = s;
            p   = ply;
            r   = v;
            if (v >= lim)
                r = storing ? v + p : v - p;
            else if (v <= -lim)
                r = storing ? v - p : v + p;
            return r[15:0];
        endfunction

        function void note_command(t_cmd c);
            t_rsp                      r;
            t_slot                     s;
            logic [INDEX_BITS_DEF-1:0] ix;
            int                        n;
            r  = '0;
            ix = c.lookup_key[INDEX_BITS_DEF-1:0];
            s  = slots[ix];
            n  = 0;
            case (c.func)
                FUNC_PROBE: begin
                    probes++;
                    if (s.key == c.lookup_key && s.flag != 2'd0) begin
                        hits++;
                        r.hit            = 1'b1;
                        r.entry_score    = s.score;
                        r.adjusted_score = mate_shift(s.score, c.ply_from_root, 1'b0);
                        r.entry_eval     = s.eval;
                        r.entry_move     = s.move;
                        r.entry_depth    = s.depth;
                        r.entry_flag     = s.flag;
                        r.entry_age      = s.age;
                    end
                end
                FUNC_STORE: begin
                    stores++;
                    if (s.key != c.lookup_key || c.search_depth >= s.depth || s.age != cur_age) begin
                        // keep the old move on a same-key store that gives none
                        if (!(c.best_move == 16'd0 && s.key == c.lookup_key))
                            s.move = c.best_move;
                        s.key   = c.lookup_key;
                        s.score = mate_shift(c.result_score, c.ply_from_root, 1'b1);
                        s.eval  = c.static_eval;
                        s.depth = c.search_depth;
                        s.flag  = c.bound_kind;
                        s.age   = cur_age;
                        slots[ix] = s;
                    end
                end
                FUNC_CLEAR: begin
                    clears++;
                    wipe_slots();
                end
                default: begin
                    fills++;
                    for (int i = 0; i < FILL_WINDOW; i++)
                        if (slots[i].flag != 2'd0 && slots[i].age == cur_age)
                            n++;
                    r.fill_count = (n > 1023) ? FILL_MAX : n[9:0];
                end
            endcase
            predicted_rsp.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (predicted_rsp.size() == 0) begin
                mismatches++;
                $error("response word with no prediction waiting");
                return;
            end
            want = predicted_rsp.pop_front();
            compare("hit",            want.hit,            got.hit);
            compare("entry_score",    want.entry_score,    got.entry_score);
            compare("adjusted_score", want.adjusted_score, got.adjusted_score);
            compare("entry_eval",     want.entry_eval,     got.entry_eval);
            compare("entry_move",     want.entry_move,     got.entry_move);
            compare("entry_depth",    want.entry_depth,    got.entry_depth);
            compare("entry_flag",     want.entry_flag,     got.entry_flag);
            compare("entry_age",      want.entry_age,      got.entry_age);
            compare("fill_count",     want.fill_count,     got.fill_count);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_cmd                  i_cmd;
    logic                  o_done;
    t_rsp                  o_rsp;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    search_cache_scoreboard board;
    logic [47:0]            tag_pool [0:3];
    logic [15:0]            hot_index [0:15];
    logic [63:0]            last_stored;
    int                     cycles;
    int                     settings_run;

    direct_mapped_search_cache u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("direct_mapped_search_cache: mismatch");
            $finish;
        end
    end

    // Check every response word in the cycle it is marked
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            board.check_response(o_rsp);
    end

    // Hold the command word until the block takes it; leave start high
    task automatic issue(input t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        board.note_command(c);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending and wait for every predicted word to come back
    task automatic drain();
        start <= 1'b0;
        while (board.predicted_rsp.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [7:0] age, input logic [14:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_CURRENT_AGE;
        i_cfg_data  <= {7'd0, age};
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        board.set_register(CFG_CURRENT_AGE, {7'd0, age});
        i_cfg_index <= CFG_MATE_THRESHOLD;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        board.set_register(CFG_MATE_THRESHOLD, limit);
        i_cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // Narrow fields take plain integers and keep their low bits
    function automatic t_cmd make_cmd(logic [1:0] func, logic [63:0] key, int depth,
                                      int score, int eval,
                                      int flag, int move, int ply);
        t_cmd c;
        c.func          = func;
        c.lookup_key    = key;
        c.search_depth  = 8'(depth);
        c.result_score  = 16'(score);
        c.static_eval   = 16'(eval);
        c.bound_kind    = 2'(flag);
        c.best_move     = 16'(move);
        c.ply_from_root = 8'(ply);
        return c;
    endfunction

    // Mostly hot slots with a few tags each, so hits and collisions are common
    function automatic logic [63:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return {tag_pool[$urandom_range(0, 3)], hot_index[$urandom_range(0, 15)]};
        return {$urandom, $urandom};
    endfunction

    // Favor scores at and around the mate threshold
    function automatic logic [15:0] pick_score();
        int lim, v;
        lim = board.mate_limit;
        case ($urandom_range(0, 9))
            0:       v = lim + $urandom_range(0, 3);
            1:       v = -lim - $urandom_range(0, 3);
            2:       v = lim - 1;
            3:       v = 32767;
            4:       v = -32768;
            default: v = $urandom;
        endcase
        return v[15:0];
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   r;
        c = make_cmd(FUNC_PROBE, pick_key(), $urandom, pick_score(), $urandom, $urandom,
                     ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom), $urandom);
        r = $urandom_range(0, 999);
        if (r < 2)
            c.func = FUNC_CLEAR;
        else if (r < 32)
            c.func = FUNC_FILL;
        else if (r < 520)
            c.func = FUNC_STORE;
        // follow a store with a probe of the same key half the time
        if (c.func == FUNC_PROBE && $urandom_range(0, 1) == 1)
            c.lookup_key = last_stored;
        if (c.func == FUNC_STORE)
            last_stored = c.lookup_key;
        return c;
    endfunction

    initial begin
        localparam logic [63:0] KEY_A = 64'h0123_4567_89AB_0005;
        localparam logic [63:0] KEY_B = 64'hFEDC_BA98_7654_0005;
        localparam logic [63:0] KEY_TOP = 64'hFFFF_FFFF_FFFF_FFFF;
        t_cmd directed [$];
        int   burst;
        logic [7:0]  ages [0:4];
        logic [14:0] limits [0:4];

        board = new();
        cycles       = 0;
        settings_run = 0;
        last_stored  = KEY_A;
        tag_pool[0]  = 48'h0;
        tag_pool[1]  = 48'hFFFF_FFFF_FFFF;
        tag_pool[2]  = {$urandom, 16'($urandom)};
        tag_pool[3]  = {$urandom, 16'($urandom)};
        hot_index[0] = 16'd0;
        hot_index[1] = 16'd5;
        hot_index[2] = 16'd999;
        hot_index[3] = 16'd1000;
        hot_index[4] = 16'hFFFF;
        for (int i = 5; i < 16; i++)
            hot_index[i] = 16'($urandom_range(0, 999));

        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_CURRENT_AGE;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words, run with the register reset values
        directed.push_back(make_cmd(FUNC_PROBE, 64'd0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FUNC_FILL, 64'd0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FUNC_STORE, KEY_A, 10, 31500, 16'h8000, 3, 16'hFFFF, 20));
        directed.push_back(make_cmd(FUNC_PROBE, KEY_A, 0, 0, 0, 0, 0, 7));
        directed.push_back(make_cmd(FUNC_STORE, KEY_A, 5, 100, 1, 2, 16'h1234, 0));
        directed.push_back(make_cmd(FUNC_PROBE, KEY_A, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FUNC_STORE, KEY_A, 10, 16'h8000, 2, 1, 16'd0, 255));
        directed.push_back(make_cmd(FUNC_PROBE, KEY_A, 0, 0, 0, 0, 0, 255));
        directed.push_back(make_cmd(FUNC_STORE, KEY_B, 0, -31000, 3, 1, 16'd1, 3));
        directed.push_back(make_cmd(FUNC_PROBE, KEY_A, 0, 0, 0, 0, 0, 1));
        directed.push_back(make_cmd(FUNC_PROBE, KEY_B, 0, 0, 0, 0, 0, 2));
        directed.push_back(make_cmd(FUNC_STORE, KEY_B, 0, 5, 5, 0, 16'd9, 0));
        directed.push_back(make_cmd(FUNC_PROBE, KEY_B, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FUNC_STORE, KEY_TOP, 255, 32767, 32767, 3, 0, 255));
        directed.push_back(make_cmd(FUNC_PROBE, KEY_TOP, 255, 16'hFFFF, 16'hFFFF, 3,
                                    16'hFFFF, 0));
        directed.push_back(make_cmd(FUNC_STORE, {48'hA5A5_5A5A_0F0F, 16'd999}, 1, 7, 7, 2, 7, 0));
        directed.push_back(make_cmd(FUNC_STORE, {48'h1, 16'd1000}, 1, 8, 8, 2, 8, 0));
        directed.push_back(make_cmd(FUNC_STORE, 64'h1_0000, 2, 31000, 9, 3, 9, 4));
        directed.push_back(make_cmd(FUNC_FILL, 64'd0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FUNC_STORE, KEY_A, 3, 30999, 4, 1, 16'h8001, 9));
        directed.push_back(make_cmd(FUNC_PROBE, KEY_A, 0, 0, 0, 0, 0, 9));
        directed.push_back(make_cmd(FUNC_CLEAR, 64'd0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FUNC_PROBE, KEY_A, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(FUNC_FILL, 64'd0, 0, 0, 0, 0, 0, 0));
        foreach (directed[i])
            issue(directed[i]);
        drain();

        // Random phases, each under its own register setting
        ages[0] = 8'd255;  limits[0] = 15'd32767;
        ages[1] = 8'd0;    limits[1] = 15'd0;
        ages[2] = 8'd1;    limits[2] = 15'd31000;
        ages[3] = 8'($urandom); limits[3] = 15'($urandom);
        ages[4] = 8'd254;  limits[4] = 15'($urandom_range(30000, 32767));
        for (int ph = 0; ph < 5; ph++) begin
            write_settings(ages[ph], limits[ph]);
            burst = $urandom_range(1, 40);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                issue(random_cmd());
                burst--;
                // end of a burst: drop start for a short or a long gap
                if (burst == 0) begin
                    pause(($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                      : $urandom_range(1, 6));
                    burst = $urandom_range(1, 40);
                end
            end
            drain();
        end

        $display("Covered %0d probes (%0d hits), %0d stores, %0d clears, %0d fill counts",
                 board.probes, board.hits, board.stores, board.clears, board.fills);
        $display("across the reset values and %0d written register settings", settings_run);
        if (board.mismatches == 0 && board.predicted_rsp.size() == 0) begin
            $display("direct_mapped_search_cache: match");
        end else begin
            $display("direct_mapped_search_cache: mismatch");
        end
        $finish;
    end

endmodule
